>>> hdl/gtr_pkg.sv
// Package for the 3x5 glyph text rasteriser: glyph ROM, character codes,
// controller states and the command/status structs between the two halves.
// No dependencies.
package gtr_pkg;

  localparam int unsigned NUM_GLYPHS  = 15;
  localparam int unsigned GLYPH_COLS  = 3;
  localparam int unsigned GLYPH_ROWS  = 5;
  localparam int unsigned NUM_CELLS   = GLYPH_COLS * GLYPH_ROWS;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned SIZE_W      = 5;
  // widest offset is the line advance, 6 * 16 = 96
  localparam int unsigned OFFS_W      = 7;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(1);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(16);

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_A       = 8'h61;
  localparam logic [7:0] CHAR_M       = 8'h6D;
  localparam logic [7:0] CHAR_X       = 8'h78;

  localparam logic [SLOT_W-1:0] SLOT_M     = SLOT_W'(10);
  localparam logic [SLOT_W-1:0] SLOT_A     = SLOT_W'(11);
  localparam logic [SLOT_W-1:0] SLOT_X     = SLOT_W'(12);
  localparam logic [SLOT_W-1:0] SLOT_SPACE = SLOT_W'(13);
  localparam logic [SLOT_W-1:0] SLOT_COLON = SLOT_W'(14);

  // Row bitmaps, top row first; bit x of a row is column x.
  localparam logic [GLYPH_COLS-1:0] GLYPH_ROM [NUM_GLYPHS][GLYPH_ROWS] = '{
    '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7},  // 0
    '{3'd4, 3'd6, 3'd5, 3'd4, 3'd4},  // 1
    '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},  // 2
    '{3'd7, 3'd4, 3'd7, 3'd4, 3'd7},  // 3
    '{3'd5, 3'd5, 3'd7, 3'd4, 3'd4},  // 4
    '{3'd5, 3'd1, 3'd7, 3'd4, 3'd7},  // 5
    '{3'd7, 3'd1, 3'd7, 3'd5, 3'd7},  // 6
    '{3'd7, 3'd4, 3'd4, 3'd4, 3'd4},  // 7
    '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7},  // 8
    '{3'd7, 3'd5, 3'd7, 3'd4, 3'd7},  // 9
    '{3'd5, 3'd7, 3'd7, 3'd5, 3'd5},  // m
    '{3'd7, 3'd5, 3'd7, 3'd5, 3'd5},  // a
    '{3'd5, 3'd5, 3'd2, 3'd5, 3'd5},  // x
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},  // space
    '{3'd0, 3'd2, 3'd0, 3'd2, 3'd0}   // colon
  };

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } gtr_state_e;

  typedef struct packed {
    logic                valid;
    logic [SLOT_W-1:0]   slot;
  } glyph_lookup_t;

  typedef struct packed {
    logic load;   // take the offered character
    logic step;   // move on to the next cell
  } gtr_cmd_t;

  typedef struct packed {
    logic has_cells;  // offered character has at least one set cell
    logic scan_last;  // current cell is the last set one
    logic out_free;   // output register can take a square this cycle
  } gtr_status_t;

  function automatic glyph_lookup_t glyph_slot(logic [7:0] code);
    glyph_lookup_t res;
    res = '0;
    if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
      res.valid = 1'b1;
      res.slot  = SLOT_W'(code - CHAR_ZERO);
    end else begin
      unique case (code)
        CHAR_M:     res = '{valid: 1'b1, slot: SLOT_M};
        CHAR_A:     res = '{valid: 1'b1, slot: SLOT_A};
        CHAR_X:     res = '{valid: 1'b1, slot: SLOT_X};
        CHAR_SPACE: res = '{valid: 1'b1, slot: SLOT_SPACE};
        CHAR_COLON: res = '{valid: 1'b1, slot: SLOT_COLON};
        default:    res = '0;
      endcase
    end
    return res;
  endfunction

  // Cells in scan order: column by column, bottom row first within a column.
  function automatic logic [NUM_CELLS-1:0] glyph_scan(glyph_lookup_t lk);
    logic [NUM_CELLS-1:0]  m;
    logic [GLYPH_COLS-1:0] row;
    m = '0;
    if (lk.valid && lk.slot < SLOT_W'(NUM_GLYPHS)) begin
      for (int cx = 0; cx < GLYPH_COLS; cx++) begin
        for (int cy = 0; cy < GLYPH_ROWS; cy++) begin
          row = GLYPH_ROM[lk.slot][GLYPH_ROWS - 1 - cy];
          m[cx * GLYPH_ROWS + cy] = row[cx];
        end
      end
    end
    return m;
  endfunction

endpackage

>>> hdl/gtr_ctrl.sv
// Controller for the 3x5 glyph text rasteriser: idle/scan state machine.
// Depends on gtr_pkg.
module gtr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gtr_pkg::gtr_status_t status_i,
  output gtr_pkg::gtr_cmd_t    cmd_o
);
  import gtr_pkg::*;

  gtr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.has_cells) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.out_free && status_i.scan_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.step = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
        cmd_o      = '0;
      end
    endcase
  end

  // a new character is only taken with the scan of the previous one finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !cmd_o.step)
    else $error("load and step together");

  // leaving the scan needs the final square to have gone into the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && state_d == ST_IDLE) |-> cmd_o.step)
    else $error("scan ended without emitting its last square");

endmodule

>>> hdl/gtr_datapath.sv
// Datapath for the 3x5 glyph text rasteriser: size register, cursor, cell
// scan counters, glyph ROM lookup and the output register. Depends on gtr_pkg.
module gtr_datapath #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gtr_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  logic [7:0]                    char_code_i,
  input  logic                          first_of_string_i,
  input  logic [COORD_BITS-1:0]         start_x_i,
  input  logic [COORD_BITS-1:0]         start_y_i,
  input  gtr_pkg::gtr_cmd_t             cmd_i,
  output gtr_pkg::gtr_status_t          status_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [COORD_BITS-1:0]         rect_x_o,
  output logic [COORD_BITS-1:0]         rect_y_o,
  output logic [gtr_pkg::SIZE_W-1:0]    rect_side_o,
  output logic                          last_of_glyph_o
);
  import gtr_pkg::*;

  logic [SIZE_W-1:0]     pixel_size_q;
  logic [SIZE_W-1:0]     size_eff;
  logic [COORD_BITS-1:0] cursor_x_q, cursor_x_d;
  logic [COORD_BITS-1:0] cursor_y_q, cursor_y_d;
  logic [COORD_BITS-1:0] line_start_q, line_start_d;
  logic [COORD_BITS-1:0] glyph_x_q, glyph_y_q;
  logic [NUM_CELLS-1:0]  scan_q;
  logic [1:0]            col_q;
  logic [2:0]            row_q;
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] rect_x_q, rect_y_q;
  logic [SIZE_W-1:0]     rect_side_q;
  logic                  last_q;

  glyph_lookup_t         lookup;
  logic [NUM_CELLS-1:0]  new_scan;
  logic [COORD_BITS-1:0] base_x, base_y, base_ls;
  logic [OFFS_W-1:0]     adv_x, adv_y, off_x, off_y;
  logic                  out_free;

  always_comb begin
    if (pixel_size_q == '0)          size_eff = SIZE_MIN;
    else if (pixel_size_q > SIZE_MAX) size_eff = SIZE_MAX;
    else                              size_eff = pixel_size_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      pixel_size_q <= cfg_wdata_i;
    end
  end

  assign lookup   = glyph_slot(char_code_i);
  assign new_scan = glyph_scan(lookup);

  assign adv_x = OFFS_W'(size_eff) << 2;
  assign adv_y = (OFFS_W'(size_eff) << 2) + (OFFS_W'(size_eff) << 1);
  assign off_x = OFFS_W'(col_q) * OFFS_W'(size_eff);
  assign off_y = OFFS_W'(row_q) * OFFS_W'(size_eff);

  // cursor update happens on the transfer; the glyph keeps its own origin
  always_comb begin
    base_x  = first_of_string_i ? start_x_i : cursor_x_q;
    base_y  = first_of_string_i ? start_y_i : cursor_y_q;
    base_ls = first_of_string_i ? start_x_i : line_start_q;
    cursor_x_d   = base_x;
    cursor_y_d   = base_y;
    line_start_d = base_ls;
    if (char_code_i == CHAR_NEWLINE) begin
      cursor_x_d = base_ls;
      cursor_y_d = base_y + COORD_BITS'(adv_y);
    end else if (lookup.valid) begin
      cursor_x_d = base_x + COORD_BITS'(adv_x);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      line_start_q <= '0;
    end else if (cmd_i.load) begin
      cursor_x_q   <= cursor_x_d;
      cursor_y_q   <= cursor_y_d;
      line_start_q <= line_start_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (cmd_i.load) begin
      scan_q <= new_scan;
      col_q  <= '0;
      row_q  <= 3'(GLYPH_ROWS - 1);
    end else if (cmd_i.step) begin
      scan_q <= scan_q >> 1;
      if (row_q == '0) begin
        row_q <= 3'(GLYPH_ROWS - 1);
        col_q <= col_q + 2'd1;
      end else begin
        row_q <= row_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      glyph_x_q <= base_x;
      glyph_y_q <= base_y;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step && scan_q[0]) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && scan_q[0]) begin
      rect_x_q    <= glyph_x_q + COORD_BITS'(off_x);
      rect_y_q    <= glyph_y_q + COORD_BITS'(off_y);
      rect_side_q <= size_eff;
      last_q      <= (scan_q[NUM_CELLS-1:1] == '0);
    end
  end

  assign status_o.has_cells = (new_scan != '0);
  assign status_o.scan_last = (scan_q[NUM_CELLS-1:1] == '0);
  assign status_o.out_free  = out_free;

  assign out_valid_o     = out_valid_q;
  assign rect_x_o        = rect_x_q;
  assign rect_y_o        = rect_y_q;
  assign rect_side_o     = rect_side_q;
  assign last_of_glyph_o = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (scan_q != '0))
    else $error("scan step with no cells left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> out_free)
    else $error("scan step would overwrite a waiting square");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_eff >= SIZE_MIN) && (size_eff <= SIZE_MAX))
    else $error("effective pixel size out of range");

endmodule

>>> hdl/glyph_3x5_text_rasterizer_unit.sv
// Top level of the 3x5 glyph text rasteriser: controller plus datapath.
// Depends on gtr_pkg, gtr_ctrl and gtr_datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o | char_code, first_of_string, start_x/y
//  out     | output    | out_valid_o/out_stall_i | rect_x, rect_y, rect_side, last_of_glyph
//  cfg     | input     | cfg_we_i               | cfg_wdata_i (pixel_size)
//
// Scan: newline, space and unknown codes need no scan. A glyph is taken by the
//   transfer and then scanned cell by cell, up to the last set cell (at most
//   15 cells), while the input is stalled.
// Reset: pixel size 4, cursor, line start and output valid cleared.
// Stalls: a stalled output holds the scan; the output register still lets the
//   next character's transfer in while the final square waits.
module glyph_3x5_text_rasterizer_unit #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [gtr_pkg::SIZE_W-1:0] cfg_wdata_i,
  // character input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 char_code_i,
  input  logic                       first_of_string_i,
  input  logic [COORD_BITS-1:0]      start_x_i,
  input  logic [COORD_BITS-1:0]      start_y_i,
  // square output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [COORD_BITS-1:0]      rect_x_o,
  output logic [COORD_BITS-1:0]      rect_y_o,
  output logic [gtr_pkg::SIZE_W-1:0] rect_side_o,
  output logic                       last_of_glyph_o
);
  import gtr_pkg::*;

  gtr_cmd_t    cmd;
  gtr_status_t status;

  // state machine: idle waits for a transfer, scan walks the glyph cells
  gtr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // cursor, glyph ROM, cell offsets and output register
  gtr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .char_code_i       (char_code_i),
    .first_of_string_i (first_of_string_i),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .rect_x_o          (rect_x_o),
    .rect_y_o          (rect_y_o),
    .rect_side_o       (rect_side_o),
    .last_of_glyph_o   (last_of_glyph_o)
  );

endmodule
